[rtl/mvsm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_pkg: shared types and constants of the sample playback mixer
// Item structs, operation codes and the saturation helper.
// ----------------------------------------------------------------------------
package mvsm_pkg;

	localparam int unsigned MaxVoicesDef   = 16;
	localparam int unsigned SampleWordsDef = 65536;
	localparam logic [15:0] GainReset      = 16'd22938;
	localparam logic [16:0] FullLength     = 17'd65536;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_PLAY   = 3'd1,
		OP_STOP   = 3'd2,
		OP_SETBG  = 3'd3,
		OP_CLRBG  = 3'd4,
		OP_TICK   = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [15:0]        address;
		logic signed [15:0] sample_value;
		logic [16:0]        sound_length;
		logic               loop_flag;
		logic [7:0]         sound_tag;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] mixed_sample;
		logic               accepted;
		logic [4:0]         active_voices;
	} out_item_t;

	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		if (v > 34'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -34'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage
`default_nettype wire

[rtl/mvsm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module mvsm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

[rtl/mvsm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_front: input stage and command queue
// Accepts items, normalizes the length and holds up to two for the back end.
// ----------------------------------------------------------------------------
module mvsm_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	output logic                    full,
	input  wire mvsm_pkg::in_item_t in_item,
	output logic                    cmd_valid,
	output mvsm_pkg::in_item_t      cmd,
	input  wire                     cmd_take
);
	import mvsm_pkg::*;

	in_item_t  slot_q [2];
	logic      rd_q, wr_q;
	logic [1:0] cnt_q;
	in_item_t  norm;

	always_comb begin
		norm = in_item;
		if (in_item.sound_length > FullLength) begin
			norm.sound_length = FullLength;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= norm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, cmd_take};
		end
	end
endmodule
`default_nettype wire

[rtl/mvsm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_back: voice list, mixer sequencer and result register
// Executes one command at a time and walks the voice list on a tick or a stop.
// ----------------------------------------------------------------------------
module mvsm_back #(
	parameter int unsigned MAX_VOICES   = mvsm_pkg::MaxVoicesDef,
	parameter int unsigned SAMPLE_WORDS = mvsm_pkg::SampleWordsDef
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cmd_valid,
	input  wire mvsm_pkg::in_item_t cmd,
	output logic                    cmd_take,
	input  wire [15:0]              gain,
	output logic                    res_valid,
	output mvsm_pkg::out_item_t     res,
	input  wire                     res_take,
	output logic                    busy
);
	import mvsm_pkg::*;

	localparam int unsigned VW = $clog2(MAX_VOICES) > 0 ? $clog2(MAX_VOICES) : 1;
	localparam int unsigned CW = $clog2(MAX_VOICES + 1);
	localparam int unsigned AW = $clog2(SAMPLE_WORDS);

	typedef enum logic [2:0] {
		S_IDLE, S_BG_RD, S_V_RD, S_SCALE, S_ADD, S_STOP, S_DONE
	} state_t;

	state_t state_q;
	logic [15:0] v_base_q [MAX_VOICES];
	logic [16:0] v_len_q  [MAX_VOICES];
	logic [16:0] v_pos_q  [MAX_VOICES];
	logic        v_loop_q [MAX_VOICES];
	logic [7:0]  v_tag_q  [MAX_VOICES];
	logic [CW-1:0] count_q;
	logic [15:0] b_base_q;
	logic [16:0] b_len_q, b_pos_q;
	logic        b_loop_q, b_en_q;
	logic [CW-1:0] i_q, w_q;
	logic        bg_q;
	logic        play_q;
	logic signed [15:0] acc_q;
	logic signed [33:0] prod_q;
	logic        acc_flag_q;
	logic [7:0]  tag_q;
	out_item_t   res_q;
	logic        res_valid_q;

	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [15:0]    ram_rdata;
	logic [VW-1:0]  iv, wv;
	logic [16:0]    pos_nx;
	logic           keep;
	logic signed [33:0] qv;
	logic signed [15:0] scaled;
	logic [16:0]    addr_sum;

	assign iv = i_q[VW-1:0];
	assign wv = w_q[VW-1:0];

	mvsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cmd.sample_value),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we   = (state_q == S_IDLE) && cmd_valid && !res_valid_q &&
			(cmd.op == OP_WRITE);
		addr_sum = 17'd0;
		if (state_q == S_IDLE) begin
			addr_sum = {1'b0, cmd.address};
		end else if (state_q == S_BG_RD) begin
			addr_sum = {1'b0, b_base_q} + b_pos_q;
		end else begin
			addr_sum = {1'b0, v_base_q[iv]} + v_pos_q[iv];
		end
		ram_addr = AW'(addr_sum);
	end

	always_comb begin
		if (prod_q < 0) begin
			qv = -((-prod_q) >>> 15);
		end else begin
			qv = prod_q >>> 15;
		end
		scaled = sat16(qv);
		pos_nx = v_pos_q[iv] + 17'd1;
		keep = 1'b1;
		if (v_pos_q[iv] < v_len_q[iv]) begin
			if (pos_nx >= v_len_q[iv] && !v_loop_q[iv]) begin
				keep = 1'b0;
			end
		end else if (!v_loop_q[iv]) begin
			keep = 1'b0;
		end
	end

	assign cmd_take  = (state_q == S_IDLE) && cmd_valid && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign busy      = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			b_en_q      <= 1'b0;
			b_base_q    <= '0;
			b_len_q     <= '0;
			b_pos_q     <= '0;
			b_loop_q    <= 1'b0;
			res_valid_q <= 1'b0;
			i_q         <= '0;
			w_q         <= '0;
			bg_q        <= 1'b0;
			play_q      <= 1'b0;
			acc_q       <= '0;
			prod_q      <= '0;
			acc_flag_q  <= 1'b0;
			tag_q       <= '0;
			res_q       <= '0;
			for (int k = 0; k < MAX_VOICES; k++) begin
				v_base_q[k] <= '0;
				v_len_q[k]  <= '0;
				v_pos_q[k]  <= '0;
				v_loop_q[k] <= 1'b0;
				v_tag_q[k]  <= '0;
			end
		end else begin
			if (res_take) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						acc_q      <= '0;
						acc_flag_q <= 1'b0;
						i_q        <= '0;
						w_q        <= '0;
						tag_q      <= cmd.sound_tag;
						case (cmd.op)
							OP_PLAY: begin
								if (count_q < CW'(MAX_VOICES)) begin
									v_base_q[count_q[VW-1:0]] <= cmd.address;
									v_len_q[count_q[VW-1:0]]  <= cmd.sound_length;
									v_pos_q[count_q[VW-1:0]]  <= '0;
									v_loop_q[count_q[VW-1:0]] <= cmd.loop_flag;
									v_tag_q[count_q[VW-1:0]]  <= cmd.sound_tag;
									count_q    <= count_q + 1'b1;
									acc_flag_q <= 1'b1;
								end
								state_q <= S_DONE;
							end
							OP_STOP: state_q <= S_STOP;
							OP_SETBG: begin
								b_base_q <= cmd.address;
								b_len_q  <= cmd.sound_length;
								b_pos_q  <= '0;
								b_loop_q <= cmd.loop_flag;
								b_en_q   <= 1'b1;
								state_q  <= S_DONE;
							end
							OP_CLRBG: begin
								b_en_q  <= 1'b0;
								state_q <= S_DONE;
							end
							OP_TICK: begin
								if (b_en_q && b_pos_q < b_len_q) begin
									state_q <= S_BG_RD;
								end else begin
									state_q <= S_V_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_BG_RD: begin
					bg_q    <= 1'b1;
					play_q  <= 1'b1;
					state_q <= S_SCALE;
					if (b_pos_q + 17'd1 >= b_len_q && b_loop_q) begin
						b_pos_q <= '0;
					end else begin
						b_pos_q <= b_pos_q + 17'd1;
					end
				end
				S_V_RD: begin
					bg_q <= 1'b0;
					if (i_q >= count_q) begin
						count_q <= w_q;
						state_q <= S_DONE;
					end else begin
						play_q <= (v_pos_q[iv] < v_len_q[iv]);
						if (keep) begin
							v_base_q[wv] <= v_base_q[iv];
							v_len_q[wv]  <= v_len_q[iv];
							v_loop_q[wv] <= v_loop_q[iv];
							v_tag_q[wv]  <= v_tag_q[iv];
							v_pos_q[wv]  <= (v_pos_q[iv] < v_len_q[iv] &&
								pos_nx >= v_len_q[iv]) ? 17'd0 :
								(v_pos_q[iv] < v_len_q[iv] ? pos_nx : v_pos_q[iv]);
							w_q <= w_q + 1'b1;
						end
						i_q     <= i_q + 1'b1;
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					prod_q  <= $signed(ram_rdata) * $signed({18'd0, gain});
					state_q <= play_q ? S_ADD : S_V_RD;
				end
				S_ADD: begin
					if (bg_q) begin
						acc_q <= scaled;
					end else begin
						acc_q <= sat16(34'(acc_q) + 34'(scaled));
					end
					state_q <= S_V_RD;
				end
				S_STOP: begin
					if (i_q >= count_q) begin
						if (acc_flag_q) begin
							count_q <= count_q - 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						if (acc_flag_q) begin
							v_base_q[iv - 1'b1] <= v_base_q[iv];
							v_len_q[iv - 1'b1]  <= v_len_q[iv];
							v_pos_q[iv - 1'b1]  <= v_pos_q[iv];
							v_loop_q[iv - 1'b1] <= v_loop_q[iv];
							v_tag_q[iv - 1'b1]  <= v_tag_q[iv];
						end else if (v_tag_q[iv] == tag_q) begin
							acc_flag_q <= 1'b1;
						end
						i_q <= i_q + 1'b1;
					end
				end
				S_DONE: begin
					res_q.mixed_sample  <= acc_q;
					res_q.accepted      <= acc_flag_q;
					res_q.active_voices <= 5'(count_q);
					res_valid_q         <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/multi_voice_sample_mixer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_core: sample playback mixer top level
// Input items enter through a push/full queue port; each produces exactly one
// result item, read through an empty/pop port. A two-entry command queue sits
// ahead of the sequencer, and the result register frees the sequencer as
// soon as it is read. Writes, plays, background changes and unknown codes
// go from queue head through the done state to the result register. A stop
// walks the voice list. A tick reads and scales the background sample to
// start the sum, then handles each playing voice in turn (sample memory read,
// gain multiply, saturating add). The single sample memory port and the
// shared multiplier make the voices go one after another. The master gain
// is written through its own valid/ready channel, which is ready while the
// block is idle. Reset clears the voice list and background and loads gain
// 0.7; the sample memory holds garbage until written. When pop is held low,
// the finished result waits and the sequencer stalls; the queue then fills
// and raises full.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_core #(
	parameter int unsigned MAX_VOICES   = mvsm_pkg::MaxVoicesDef,
	parameter int unsigned SAMPLE_WORDS = mvsm_pkg::SampleWordsDef
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	output logic                    full,
	input  wire mvsm_pkg::in_item_t in_item,
	output logic                    empty,
	input  wire                     pop,
	output mvsm_pkg::out_item_t     out_item,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [15:0]              cfg_data
);
	import mvsm_pkg::*;

	logic       cmd_valid, cmd_take, res_valid, busy;
	in_item_t   cmd;
	logic [15:0] gain_q;

	assign cfg_ready = !busy;
	assign empty     = !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	mvsm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	mvsm_back #(.MAX_VOICES(MAX_VOICES), .SAMPLE_WORDS(SAMPLE_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .gain(gain_q), .res_valid(res_valid), .res(out_item),
		.res_take(pop && res_valid), .busy(busy)
	);
endmodule
`default_nettype wire

[sim/multi_voice_sample_mixer_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_core_test: testbench of the sample playback mixer
// Drives command items through the push/full port and checks every result item
// against a predictor of the sample memory, voice list, background and gain.
// A memory preload and directed cases come first, then gain sweeps and a long
// random mix with random gaps on both sides outside its one steady phase.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_core_test;
	import mvsm_pkg::*;

	localparam logic [2:0] OpSpare6 = 3'd6;
	localparam logic [2:0] OpSpare7 = 3'd7;
	localparam int WatchLimit = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [15:0] cfg_data = '0;
	in_item_t in_item = '0;
	logic full, empty, cfg_ready;
	out_item_t out_item;

	multi_voice_sample_mixer_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	logic signed [15:0] sample_mem [0:65535];
	int unsigned v_base [16], v_len [16], v_pos [16], v_loop [16], v_tag [16];
	int unsigned v_count, bg_base, bg_len, bg_pos, bg_loop, bg_on, gain;
	out_item_t expected_results [$];
	bit failed = 1'b0;
	bit steady = 1'b0;
	int quiet_cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int sat16i(longint v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return int'(v);
	endfunction

	function automatic int gain_scale(int s);
		longint p;
		p = longint'(s) * longint'(gain);
		if (p < 0) begin
			return sat16i(-((-p) >>> 15));
		end
		return sat16i(p >>> 15);
	endfunction

	function automatic int mix_tick();
		longint acc;
		int unsigned w;
		bit keep;
		acc = 0;
		w = 0;
		if (bg_on && bg_pos < bg_len) begin
			acc = gain_scale(sample_mem[(bg_base + bg_pos) % 65536]);
			bg_pos++;
			if (bg_pos >= bg_len && bg_loop) begin
				bg_pos = 0;
			end
		end
		for (int i = 0; i < v_count; i++) begin
			keep = 1'b1;
			if (v_pos[i] < v_len[i]) begin
				acc = sat16i(acc + gain_scale(sample_mem[(v_base[i] + v_pos[i]) % 65536]));
				v_pos[i]++;
				if (v_pos[i] >= v_len[i]) begin
					if (v_loop[i]) begin
						v_pos[i] = 0;
					end else begin
						keep = 1'b0;
					end
				end
			end else if (!v_loop[i]) begin
				keep = 1'b0;
			end
			if (keep) begin
				v_base[w] = v_base[i];
				v_len[w] = v_len[i];
				v_pos[w] = v_pos[i];
				v_loop[w] = v_loop[i];
				v_tag[w] = v_tag[i];
				w++;
			end
		end
		v_count = w;
		return int'(acc);
	endfunction

	function automatic out_item_t mixer_step(in_item_t it);
		out_item_t r;
		int unsigned len;
		r = '0;
		len = (it.sound_length > 17'd65536) ? 65536 : it.sound_length;
		case (it.op)
			OP_WRITE: begin
				sample_mem[it.address] = it.sample_value;
			end
			OP_PLAY: begin
				if (v_count < 16) begin
					v_base[v_count] = it.address;
					v_len[v_count] = len;
					v_pos[v_count] = 0;
					v_loop[v_count] = it.loop_flag;
					v_tag[v_count] = it.sound_tag;
					v_count++;
					r.accepted = 1'b1;
				end
			end
			OP_STOP: begin
				for (int i = 0; i < v_count; i++) begin
					if (v_tag[i] == it.sound_tag) begin
						for (int k = i; k + 1 < v_count; k++) begin
							v_base[k] = v_base[k + 1];
							v_len[k] = v_len[k + 1];
							v_pos[k] = v_pos[k + 1];
							v_loop[k] = v_loop[k + 1];
							v_tag[k] = v_tag[k + 1];
						end
						v_count--;
						r.accepted = 1'b1;
						break;
					end
				end
			end
			OP_SETBG: begin
				bg_base = it.address;
				bg_len = len;
				bg_pos = 0;
				bg_loop = it.loop_flag;
				bg_on = 1;
			end
			OP_CLRBG: begin
				bg_on = 0;
			end
			OP_TICK: begin
				r.mixed_sample = 16'(mix_tick());
			end
			default: begin
			end
		endcase
		r.active_voices = 5'(v_count);
		return r;
	endfunction

	function automatic in_item_t make_item(logic [2:0] op, int unsigned addr, int val,
			int unsigned len, bit lp, int unsigned tag);
		in_item_t it;
		it.op = op;
		it.address = 16'(addr);
		it.sample_value = 16'(val);
		it.sound_length = 17'(len);
		it.loop_flag = lp;
		it.sound_tag = 8'(tag);
		return it;
	endfunction

	// Voice bases stay in the preloaded regions, so no unwritten word is read.
	function automatic int unsigned pick_base();
		if ($urandom_range(0, 7) == 0) begin
			return 65530 + $urandom_range(0, 5);
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic int unsigned pick_length();
		case ($urandom_range(0, 9))
			0: return $urandom_range(65536, 131071);
			1: return $urandom_range(0, 1);
			2: return $urandom_range(100, 65536);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		push = 1'b1;
		in_item = it;
		do @(posedge clk); while (full);
		expected_results.push_back(mixer_step(it));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_gain(int unsigned g);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = 16'(g);
		do @(posedge clk); while (!cfg_ready);
		gain = g;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_preload();
		steady = 1'b1;
		send_item(make_item(OP_WRITE, 0, 32767, 0, 0, 0));
		send_item(make_item(OP_WRITE, 1, -32768, 0, 0, 0));
		for (int a = 2; a < 320; a++) begin
			send_item(make_item(OP_WRITE, a, $urandom, 0, 0, 0));
		end
		for (int a = 65530; a < 65536; a++) begin
			send_item(make_item(OP_WRITE, a, $urandom, 0, 0, 0));
		end
		steady = 1'b0;
	endtask

	task automatic test_directed();
		send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(OP_PLAY, 65535, 0, 3, 0, 255));
		send_item(make_item(OP_PLAY, 0, 0, 0, 0, 0));
		send_item(make_item(OP_PLAY, 5, 0, 0, 1, 7));
		send_item(make_item(OP_PLAY, 0, 0, 131071, 1, 128));
		send_item(make_item(OP_SETBG, 1, 0, 2, 0, 0));
		send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(OP_STOP, 0, 0, 0, 0, 7));
		send_item(make_item(OP_STOP, 0, 0, 0, 0, 99));
		send_item(make_item(OP_SETBG, 65534, 0, 4, 1, 0));
		for (int i = 0; i < 17; i++) begin
			send_item(make_item(OP_PLAY, i, 0, 3, i & 1, i & 3));
		end
		send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(OP_STOP, 0, 0, 0, 0, 1));
		send_item(make_item(OP_CLRBG, 0, 0, 0, 0, 0));
		send_item(make_item(OpSpare6, 65535, -1, 131071, 1, 255));
		send_item(make_item(OpSpare7, 0, 0, 0, 0, 0));
		send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
	endtask

	task automatic random_items(int count);
		int unsigned sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				send_item(make_item(OP_WRITE, $urandom, $urandom, 0, 0, 0));
			end else if (sel < 32) begin
				send_item(make_item(OP_PLAY, pick_base(), $urandom, pick_length(),
					$urandom_range(0, 1), ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7)));
			end else if (sel < 42) begin
				send_item(make_item(OP_STOP, $urandom, $urandom, $urandom, $urandom_range(0, 1),
					($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7)));
			end else if (sel < 47) begin
				send_item(make_item(OP_SETBG, pick_base(), $urandom, pick_length(),
					$urandom_range(0, 1), $urandom));
			end else if (sel < 50) begin
				send_item(make_item(OP_CLRBG, $urandom, $urandom, $urandom, 0, $urandom));
			end else if (sel < 52) begin
				send_item(make_item($urandom_range(0, 1) ? OpSpare6 : OpSpare7, $urandom,
					$urandom, $urandom, $urandom_range(0, 1), $urandom));
			end else begin
				send_item(make_item(OP_TICK, $urandom, $urandom, $urandom, 1, $urandom));
			end
		end
	endtask

	task automatic test_gains();
		int unsigned gains [5] = '{0, 32768, 65535, 1, 22938};
		foreach (gains[g]) begin
			write_gain(gains[g]);
			random_items(20);
		end
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 5; phase++) begin
			steady = (phase == 2);
			write_gain($urandom_range(0, 65535));
			random_items(30);
		end
		steady = 1'b0;
		write_gain(22938);
		random_items(20);
	endtask

	always begin
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			pop = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pop = 1'b1;
		do @(posedge clk); while (empty || !arst_n);
		if (expected_results.size() == 0) begin
			$error("result item with no expectation waiting");
			failed = 1'b1;
		end else begin
			out_item_t e;
			e = expected_results.pop_front();
			if (out_item.mixed_sample !== e.mixed_sample) begin
				$error("mixed_sample: expected %0d, actual %0d", e.mixed_sample,
					out_item.mixed_sample);
				failed = 1'b1;
			end
			if (out_item.accepted !== e.accepted) begin
				$error("accepted: expected %0d, actual %0d", e.accepted, out_item.accepted);
				failed = 1'b1;
			end
			if (out_item.active_voices !== e.active_voices) begin
				$error("active_voices: expected %0d, actual %0d", e.active_voices,
					out_item.active_voices);
				failed = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WatchLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		v_count = 0;
		bg_base = 0;
		bg_len = 0;
		bg_pos = 0;
		bg_loop = 0;
		bg_on = 0;
		gain = 22938;
		foreach (v_base[i]) begin
			v_base[i] = 0;
			v_len[i] = 0;
			v_pos[i] = 0;
			v_loop[i] = 0;
			v_tag[i] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_preload();
		test_directed();
		test_gains();
		test_random();
		wait_drained();
		if (!failed) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
